[hw/rtl/ssg_pkg.sv]
// Shared constants and types for the step sequencer gate block.
package ssg_pkg;

    // Default configuration
    localparam int DEPTH_DEF     = 256;
    localparam int TIME_BITS_DEF = 24;

    // Command codes
    localparam logic [3:0] CMD_SAMPLE   = 4'd0;
    localparam logic [3:0] CMD_RECORD   = 4'd1;
    localparam logic [3:0] CMD_KEY      = 4'd2;
    localparam logic [3:0] CMD_REST     = 4'd3;
    localparam logic [3:0] CMD_PLAY     = 4'd4;
    localparam logic [3:0] CMD_STOP     = 4'd5;
    localparam logic [3:0] CMD_REWIND   = 4'd6;
    localparam logic [3:0] CMD_CLEAR    = 4'd7;
    localparam logic [3:0] CMD_ALLOCATE = 4'd8;
    localparam logic [3:0] CMD_SETNOTE  = 4'd9;
    localparam logic [3:0] CMD_SETREST  = 4'd10;
    localparam logic [3:0] CMD_LONGER   = 4'd11;
    localparam logic [3:0] CMD_SHORTER  = 4'd12;
    localparam logic [3:0] CMD_QUERY    = 4'd13;

    // Event kinds
    localparam logic EV_DOWN = 1'b0;
    localparam logic EV_UP   = 1'b1;

    // Gate fraction bounds and reset value, Q0.16
    localparam logic [16:0] GATE_HIGH  = 17'd64881;
    localparam logic [16:0] GATE_LOW   = 17'd655;
    localparam logic [15:0] GATE_RESET = 16'd32768;

    // Step entry: rest flag, note, velocity
    localparam int          ENTRY_W    = 15;
    localparam logic [14:0] REST_ENTRY = 15'h4000;
    localparam logic [6:0]  FULL_VEL   = 7'd127;
    localparam logic [15:0] LEVEL_INIT = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_REC  = 2'd1,
        MODE_PLAY = 2'd2
    } t_mode;

    typedef struct packed {
        logic       ev_valid;
        logic       ev_kind;
        logic [6:0] note;
        logic [6:0] vel;
        logic       slot_is_rest;
        logic       index_error;
    } t_result;

endpackage

[hw/rtl/ssg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ssg_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/step_sequencer_gate.sv]
// Note step sequencer with clock tracking, gate length and step table editing.
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ----------------------------------------
//  input    in         i_valid / o_stall    i_cmd, i_clock_level, i_note_number,
//                                           i_key_velocity, i_slot, i_rest_count,
//                                           i_gate_change
//  result   out        o_valid / i_stall    o_event_valid, o_event_kind, o_event_note,
//                                           o_event_velocity, o_play_active,
//                                           o_slot_is_rest, o_index_error
//
// Every transaction passes through these steps from accept to the next accept: decode (table
// read issued, gate product started), evaluate (read data and product ready), hand
// off to the result register, back to idle. The registered table read and the
// registered gate multiply call for the separate decode and evaluate steps. Allocate
// appends its rests one at a time in the fill state, since the table has a single write port.
// Reset is synchronous, active low; the step table is not cleared. A new transaction
// is accepted while a result still waits under i_stall; the block holds in its
// hand-off state only if that result is still stalled when the next one is ready.
module step_sequencer_gate #(
    parameter int DEPTH     = ssg_pkg::DEPTH_DEF,
    parameter int TIME_BITS = ssg_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transaction channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_cmd,
    input  logic [15:0] i_clock_level,
    input  logic [6:0]  i_note_number,
    input  logic [6:0]  i_key_velocity,
    input  logic [7:0]  i_slot,
    input  logic [8:0]  i_rest_count,
    input  logic [15:0] i_gate_change,
    // result transaction channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_event_valid,
    output logic        o_event_kind,
    output logic [6:0]  o_event_note,
    output logic [6:0]  o_event_velocity,
    output logic        o_play_active,
    output logic        o_slot_is_rest,
    output logic        o_index_error
);

    // Table address, length and comparison widths
    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > 8) ? LW : 8;
    // Product of gate fraction (Q0.16) and period, and the shifted elapsed count
    localparam int PW = TIME_BITS + 16;
    localparam logic [LW-1:0] LEN_FULL = LW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EVAL,
        S_FILL,
        S_DONE
    } t_state;

    t_state r_state;

    // Sequencer state
    logic [LW-1:0]        r_len;
    logic [AW-1:0]        r_pos;
    ssg_pkg::t_mode       r_mode;
    logic                 r_gate;
    logic                 r_tick;
    logic signed [15:0]   r_last;
    logic [TIME_BITS-1:0] r_elapsed;
    logic [TIME_BITS-1:0] r_period;
    logic [15:0]          r_frac;

    // Captured transaction and working registers
    logic [3:0]         r_cmd;
    logic signed [15:0] r_level;
    logic [6:0]         r_note;
    logic [6:0]         r_vel;
    logic [7:0]         r_slot;
    logic [8:0]         r_count;
    logic [15:0]        r_change;
    logic [PW-1:0]      r_prod;
    ssg_pkg::t_result   r_res;

    // Table port
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [ssg_pkg::ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [ssg_pkg::ENTRY_W-1:0] ram_rdata;

    logic                 accept;
    logic [CW-1:0]        slot_ext;
    logic [AW-1:0]        slot_addr;
    logic                 slot_bad;
    logic                 slot_cmd;
    logic [AW-1:0]        len_addr;
    logic                 rd_rest;
    logic [LW-1:0]        pos_inc;
    logic [PW-1:0]        elapsed_q16;
    logic                 gate_expired;
    logic [TIME_BITS-1:0] elapsed_inc;
    logic                 level_rise;
    logic [16:0]          frac_up;
    logic [16:0]          frac_floor;
    logic                 len_full;

    // Build a note event result from a table entry
    function automatic ssg_pkg::t_result ev_result(logic kind,
                                                   logic [ssg_pkg::ENTRY_W-1:0] entry);
        ssg_pkg::t_result r;
        r          = '0;
        r.ev_valid = 1'b1;
        r.ev_kind  = kind;
        r.note     = entry[13:7];
        r.vel      = entry[6:0];
        return r;
    endfunction

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    assign slot_ext  = CW'(r_slot);
    assign slot_addr = slot_ext[AW-1:0];
    // A slot at or beyond the length is out of range; the length never exceeds DEPTH
    assign slot_bad  = slot_ext >= CW'(r_len);
    assign slot_cmd  = (r_cmd == ssg_pkg::CMD_SETNOTE) || (r_cmd == ssg_pkg::CMD_SETREST)
                    || (r_cmd == ssg_pkg::CMD_QUERY);
    assign len_addr  = r_len[AW-1:0];
    assign len_full  = (r_len == LEN_FULL);

    assign rd_rest = ram_rdata[14];
    assign pos_inc = LW'(r_pos) + LW'(1);

    // Gate closes once elapsed * 2^16 exceeds fraction * period
    assign elapsed_q16  = {r_elapsed, 16'd0};
    assign gate_expired = elapsed_q16 > r_prod;
    // Saturate the sample counter
    assign elapsed_inc  = (&r_elapsed) ? r_elapsed : r_elapsed + TIME_BITS'(1);
    assign level_rise   = r_last < r_level;

    assign frac_up    = 17'(r_frac) + 17'(r_change);
    assign frac_floor = ssg_pkg::GATE_LOW + 17'(r_change);

    // Read the current step, or the addressed slot for slot commands
    assign ram_raddr = slot_cmd ? slot_addr : r_pos;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = len_addr;
        ram_wdata = ssg_pkg::REST_ENTRY;
        if (r_state == S_EVAL) begin
            case (r_cmd) inside
                ssg_pkg::CMD_KEY: begin
                    ram_we    = (r_mode == ssg_pkg::MODE_REC) && !len_full;
                    ram_wdata = {1'b0, r_note, r_vel};
                end
                ssg_pkg::CMD_REST: begin
                    ram_we = (r_mode == ssg_pkg::MODE_REC) && !len_full;
                end
                ssg_pkg::CMD_SETNOTE: begin
                    ram_we    = !slot_bad;
                    ram_waddr = slot_addr;
                    ram_wdata = {1'b0, r_note, ssg_pkg::FULL_VEL};
                end
                ssg_pkg::CMD_SETREST: begin
                    ram_we    = !slot_bad;
                    ram_waddr = slot_addr;
                end
                default: begin
                    ram_we = 1'b0;
                end
            endcase
        end else if (r_state == S_FILL) begin
            ram_we = (r_count != 9'd0) && !len_full;
        end
    end

    ssg_ram #(
        .WIDTH (ssg_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Capture the transaction; form the gate product while the table read is in flight
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_cmd;
            r_level  <= i_clock_level;
            r_note   <= i_note_number;
            r_vel    <= i_key_velocity;
            r_slot   <= i_slot;
            r_change <= i_gate_change;
        end
        if (r_state == S_DECODE) begin
            r_prod <= PW'(r_frac) * PW'(r_period);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_pos     <= '0;
            r_mode    <= ssg_pkg::MODE_IDLE;
            r_gate    <= 1'b0;
            r_tick    <= 1'b0;
            r_last    <= ssg_pkg::LEVEL_INIT;
            r_elapsed <= '0;
            r_period  <= '0;
            r_frac    <= ssg_pkg::GATE_RESET;
            r_count   <= '0;
            r_res     <= '0;
            o_valid   <= 1'b0;
            o_event_valid    <= 1'b0;
            o_event_kind     <= 1'b0;
            o_event_note     <= '0;
            o_event_velocity <= '0;
            o_play_active    <= 1'b0;
            o_slot_is_rest   <= 1'b0;
            o_index_error    <= 1'b0;
        end else begin
            // Drop the result once taken, unless the hand-off refills it this cycle
            if (o_valid && !i_stall && (r_state != S_DONE)) begin
                o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_count <= i_rest_count;
                        r_res   <= '0;
                        r_state <= S_DECODE;
                    end
                end

                S_DECODE: begin
                    r_state <= S_EVAL;
                end

                S_EVAL: begin
                    r_state <= (r_cmd == ssg_pkg::CMD_ALLOCATE) ? S_FILL : S_DONE;
                    unique case (r_cmd) inside
                        ssg_pkg::CMD_SAMPLE: begin
                            if (r_mode == ssg_pkg::MODE_PLAY) begin
                                if (!r_gate) begin
                                    // Open the gate on the tick seen last sample
                                    if (r_tick) begin
                                        r_gate <= 1'b1;
                                        if (!rd_rest) begin
                                            r_res <= ev_result(ssg_pkg::EV_DOWN, ram_rdata);
                                        end
                                    end
                                end else if (gate_expired) begin
                                    // Close the gate and advance, wrapping at the length
                                    r_gate <= 1'b0;
                                    if (!rd_rest) begin
                                        r_res <= ev_result(ssg_pkg::EV_UP, ram_rdata);
                                    end
                                    if (pos_inc >= r_len) begin
                                        r_pos <= '0;
                                    end else begin
                                        r_pos <= pos_inc[AW-1:0];
                                    end
                                end
                            end
                            // Track the clock: a rising level is a tick, which
                            // latches the period and restarts the count
                            r_tick <= level_rise;
                            r_last <= r_level;
                            if (level_rise) begin
                                r_period  <= elapsed_inc;
                                r_elapsed <= '0;
                            end else begin
                                r_elapsed <= elapsed_inc;
                            end
                        end
                        ssg_pkg::CMD_RECORD: begin
                            r_mode <= ssg_pkg::MODE_REC;
                        end
                        ssg_pkg::CMD_KEY, ssg_pkg::CMD_REST: begin
                            if (r_mode == ssg_pkg::MODE_REC) begin
                                if (len_full) begin
                                    r_res.index_error <= 1'b1;
                                end else begin
                                    r_len <= r_len + LW'(1);
                                end
                            end
                        end
                        ssg_pkg::CMD_PLAY: begin
                            if (r_len != '0) begin
                                r_elapsed <= '0;
                                r_gate    <= 1'b0;
                                r_mode    <= ssg_pkg::MODE_PLAY;
                                // Wrap a position left stale by clear
                                if (LW'(r_pos) >= r_len) begin
                                    r_pos <= '0;
                                end
                            end
                        end
                        ssg_pkg::CMD_STOP: begin
                            r_mode <= ssg_pkg::MODE_IDLE;
                            if (r_gate) begin
                                r_gate <= 1'b0;
                                if (!rd_rest) begin
                                    r_res <= ev_result(ssg_pkg::EV_UP, ram_rdata);
                                end
                            end
                        end
                        ssg_pkg::CMD_REWIND: begin
                            r_pos <= '0;
                        end
                        ssg_pkg::CMD_CLEAR: begin
                            if (r_mode == ssg_pkg::MODE_IDLE) begin
                                r_len <= '0;
                            end
                        end
                        ssg_pkg::CMD_SETNOTE, ssg_pkg::CMD_SETREST: begin
                            r_res.index_error <= slot_bad;
                        end
                        ssg_pkg::CMD_QUERY: begin
                            r_res <= '{ev_valid: 1'b0, ev_kind: 1'b0, note: 7'd0, vel: 7'd0,
                                       slot_is_rest: !slot_bad && rd_rest,
                                       index_error: slot_bad};
                        end
                        ssg_pkg::CMD_LONGER: begin
                            if (frac_up < ssg_pkg::GATE_HIGH) begin
                                r_frac <= frac_up[15:0];
                            end
                        end
                        ssg_pkg::CMD_SHORTER: begin
                            if (17'(r_frac) > frac_floor) begin
                                r_frac <= r_frac - r_change;
                            end
                        end
                        default: begin
                            // Allocate continues in the fill state; spare codes do nothing
                        end
                    endcase
                end

                S_FILL: begin
                    // Append one rest per cycle; flag the first one that does not fit
                    if (r_count == 9'd0) begin
                        r_state <= S_DONE;
                    end else if (len_full) begin
                        r_res.index_error <= 1'b1;
                        r_state           <= S_DONE;
                    end else begin
                        r_len   <= r_len + LW'(1);
                        r_count <= r_count - 9'd1;
                    end
                end

                S_DONE: begin
                    // Hold until the result register is free or being taken
                    if (!o_valid || !i_stall) begin
                        o_valid          <= 1'b1;
                        o_event_valid    <= r_res.ev_valid;
                        o_event_kind     <= r_res.ev_kind;
                        o_event_note     <= r_res.note;
                        o_event_velocity <= r_res.vel;
                        o_play_active    <= (r_mode == ssg_pkg::MODE_PLAY);
                        o_slot_is_rest   <= r_res.slot_is_rest;
                        o_index_error    <= r_res.index_error;
                        r_state          <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[tb/sv/seq_check_pkg.sv]
// Shadow copy of the step sequencer and the in-order check of its result transactions.
package seq_check_pkg;

    import ssg_pkg::*;

    typedef struct {
        logic [3:0]  cmd;
        logic [15:0] level;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [7:0]  slot;
        logic [8:0]  rests;
        logic [15:0] delta;
    } seq_cmd_t;

    typedef struct {
        logic       ev_valid;
        logic       ev_kind;
        logic [6:0] note;
        logic [6:0] vel;
        logic       playing;
        logic       slot_rest;
        logic       idx_err;
    } seq_event_t;

    localparam longint unsigned TIME_MAX = (64'd1 << TIME_BITS_DEF) - 64'd1;

    class sequencer_shadow;
        logic [14:0]     steps [DEPTH_DEF];
        int unsigned     seq_len;
        int unsigned     step_idx;
        t_mode           mode;
        bit              gate_on;
        bit              tick_armed;
        logic [15:0]     prev_level;
        longint unsigned since_tick;
        longint unsigned period;
        int unsigned     gate_frac;
        int              mismatches;
        seq_event_t      pending_events[$];

        function new();
            restart();
        endfunction

        function void restart();
            foreach (steps[i]) steps[i] = '0;
            seq_len    = 0;
            step_idx   = 0;
            mode       = MODE_IDLE;
            gate_on    = 1'b0;
            tick_armed = 1'b0;
            prev_level = LEVEL_INIT;
            since_tick = 0;
            period     = 0;
            gate_frac  = GATE_RESET;
        endfunction

        function logic [14:0] current_step();
            return (step_idx < DEPTH_DEF) ? steps[step_idx] : '0;
        endfunction

        // Append one entry; refuse once the table is full.
        function bit append_step(logic [14:0] e);
            if (seq_len >= DEPTH_DEF) return 1'b0;
            steps[seq_len] = e;
            seq_len++;
            return 1'b1;
        endfunction

        function seq_event_t with_event(seq_event_t r, logic [14:0] e, logic kind);
            r.ev_valid = 1'b1;
            r.ev_kind  = kind;
            r.note     = e[13:7];
            r.vel      = e[6:0];
            return r;
        endfunction

        // Advance the shadow state by one command and return the result it causes.
        function seq_event_t next_event(seq_cmd_t c);
            seq_event_t  r;
            logic [14:0] e;
            int unsigned i;
            r = '{default: '0};
            case (c.cmd)
                CMD_SAMPLE: begin
                    if (mode == MODE_PLAY) begin
                        e = current_step();
                        if (!gate_on) begin
                            if (tick_armed) begin
                                gate_on = 1'b1;
                                if (!e[14]) r = with_event(r, e, EV_DOWN);
                            end
                        end else if ((since_tick << 16) > gate_frac * period) begin
                            gate_on = 1'b0;
                            if (!e[14]) r = with_event(r, e, EV_UP);
                            step_idx++;
                            if (step_idx >= seq_len) step_idx = 0;
                        end
                    end
                    if (since_tick < TIME_MAX) since_tick++;
                    tick_armed = $signed(prev_level) < $signed(c.level);
                    prev_level = c.level;
                    if (tick_armed) begin
                        period     = since_tick;
                        since_tick = 0;
                    end
                end
                CMD_RECORD: mode = MODE_REC;
                CMD_KEY, CMD_REST: begin
                    if (mode == MODE_REC) begin
                        e = (c.cmd == CMD_KEY) ? {1'b0, c.note, c.vel} : REST_ENTRY;
                        if (!append_step(e)) r.idx_err = 1'b1;
                    end
                end
                CMD_PLAY: begin
                    if (seq_len > 0) begin
                        since_tick = 0;
                        gate_on    = 1'b0;
                        mode       = MODE_PLAY;
                        if (step_idx >= seq_len) step_idx = 0;
                    end
                end
                CMD_STOP: begin
                    mode = MODE_IDLE;
                    if (gate_on) begin
                        e = current_step();
                        if (!e[14]) r = with_event(r, e, EV_UP);
                        gate_on = 1'b0;
                    end
                end
                CMD_REWIND: step_idx = 0;
                CMD_CLEAR: if (mode == MODE_IDLE) seq_len = 0;
                CMD_ALLOCATE: begin
                    for (i = 0; i < c.rests; i++) begin
                        if (!append_step(REST_ENTRY)) begin
                            r.idx_err = 1'b1;
                            break;
                        end
                    end
                end
                CMD_SETNOTE, CMD_SETREST, CMD_QUERY: begin
                    if (c.slot >= seq_len) r.idx_err = 1'b1;
                    else if (c.cmd == CMD_SETNOTE) steps[c.slot] = {1'b0, c.note, FULL_VEL};
                    else if (c.cmd == CMD_SETREST) steps[c.slot] = REST_ENTRY;
                    else r.slot_rest = steps[c.slot][14];
                end
                CMD_LONGER: if (gate_frac + c.delta < GATE_HIGH) gate_frac += c.delta;
                CMD_SHORTER: if (gate_frac > GATE_LOW + c.delta) gate_frac -= c.delta;
                default: ;
            endcase
            r.playing = (mode == MODE_PLAY);
            return r;
        endfunction

        function void accept_command(seq_cmd_t c);
            pending_events.insert(pending_events.size(), next_event(c));
        endfunction

        // Print one line per mismatch and count it.
        task report(string msg);
            mismatches++;
            $display("MISMATCH: %s", msg);
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_event(seq_event_t got);
            seq_event_t want;
            if (pending_events.size() == 0) begin
                report("result transaction with nothing expected");
                return;
            end
            want = pending_events.pop_front();
            compare_field("event_valid", got.ev_valid, want.ev_valid);
            compare_field("event_kind", got.ev_kind, want.ev_kind);
            compare_field("event_note", got.note, want.note);
            compare_field("event_velocity", got.vel, want.vel);
            compare_field("play_active", got.playing, want.playing);
            compare_field("slot_is_rest", got.slot_rest, want.slot_rest);
            compare_field("index_error", got.idx_err, want.idx_err);
        endtask
    endclass

endpackage

[tb/sv/tb.sv]
// Top-level testbench: drives the step sequencer gate and checks every result transaction.
module tb;

    import ssg_pkg::*;
    import seq_check_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int ITEM_GOAL    = 630;     // directed part plus about 600 random transactions
    localparam int STEADY_FROM  = 300;     // window of accepted transactions with no idling
    localparam int STEADY_TO    = 400;
    localparam int HOLD_AT      = 150;     // start the long result hold-off here
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 300000;

    // Unused command codes: the block must treat them as no-ops.
    localparam logic [3:0] CMD_SPARE_A = 4'd14;
    localparam logic [3:0] CMD_SPARE_B = 4'd15;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [3:0]  i_cmd;
    logic [15:0] i_clock_level;
    logic [6:0]  i_note_number;
    logic [6:0]  i_key_velocity;
    logic [7:0]  i_slot;
    logic [8:0]  i_rest_count;
    logic [15:0] i_gate_change;
    logic        o_valid;
    logic        i_stall;
    logic        o_event_valid;
    logic        o_event_kind;
    logic [6:0]  o_event_note;
    logic [6:0]  o_event_velocity;
    logic        o_play_active;
    logic        o_slot_is_rest;
    logic        o_index_error;

    sequencer_shadow shadow;
    int              accepted_count = 0;
    int              cycle_count = 0;
    int              hold_left = 0;
    bit              hold_done = 1'b0;
    bit              steady;

    step_sequencer_gate DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_clock_level    (i_clock_level),
        .i_note_number    (i_note_number),
        .i_key_velocity   (i_key_velocity),
        .i_slot           (i_slot),
        .i_rest_count     (i_rest_count),
        .i_gate_change    (i_gate_change),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_valid    (o_event_valid),
        .o_event_kind     (o_event_kind),
        .o_event_note     (o_event_note),
        .o_event_velocity (o_event_velocity),
        .o_play_active    (o_play_active),
        .o_slot_is_rest   (o_slot_is_rest),
        .o_index_error    (o_index_error)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Both sides stop idling for a stretch of transactions.
    assign steady = (accepted_count >= STEADY_FROM) && (accepted_count < STEADY_TO);

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            shadow.report($sformatf("timeout after %0d cycles with %0d results outstanding",
                                    cycle_count, shadow.pending_events.size()));
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Fill every field at random; callers overwrite what matters.
    function automatic seq_cmd_t any_fields(logic [3:0] code);
        seq_cmd_t c;
        c.cmd   = code;
        c.level = 16'($urandom);
        c.note  = 7'($urandom);
        c.vel   = 7'($urandom);
        c.slot  = 8'($urandom);
        c.rests = 9'($urandom_range(0, 256));
        c.delta = 16'($urandom);
        return c;
    endfunction

    // Keep table edits near the current length so both good and bad indexes show up,
    // allocate only a few rests, and nudge the gate by moderate amounts.
    function automatic seq_cmd_t edit_fields(logic [3:0] code);
        seq_cmd_t c;
        int       top;
        c   = any_fields(code);
        top = shadow.seq_len + 1;
        if (top > 255) top = 255;
        c.slot  = 8'($urandom_range(0, top));
        c.rests = 9'($urandom_range(0, 3));
        c.delta = 16'($urandom_range(0, 12000));
        return c;
    endfunction

    function automatic logic [3:0] pick_edit();
        case ($urandom_range(0, 5))
            0: return CMD_SETNOTE;
            1: return CMD_SETREST;
            2: return CMD_QUERY;
            3: return CMD_LONGER;
            4: return CMD_SHORTER;
            default: return CMD_REWIND;
        endcase
    endfunction

    // Commands slipped in between clock samples while the sequence runs.
    function automatic logic [3:0] pick_side();
        case ($urandom_range(0, 9))
            0: return CMD_QUERY;
            1: return CMD_LONGER;
            2: return CMD_SHORTER;
            3: return CMD_STOP;
            4: return CMD_PLAY;
            5: return CMD_REWIND;
            6: return CMD_RECORD;
            7: return CMD_KEY;
            8: return CMD_ALLOCATE;
            default: return CMD_SETNOTE;
        endcase
    endfunction

    // Offer one transaction, hold it until accepted, then note it in the shadow.
    // Called and returns at a falling edge.
    task automatic send_cmd(seq_cmd_t c);
        while (!steady && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_cmd          <= c.cmd;
        i_clock_level  <= c.level;
        i_note_number  <= c.note;
        i_key_velocity <= c.vel;
        i_slot         <= c.slot;
        i_rest_count   <= c.rests;
        i_gate_change  <= c.delta;
        i_valid        <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        shadow.accept_command(c);
        accepted_count++;
        @(negedge i_clk);
    endtask

    task automatic issue(logic [3:0] code, int note, int vel, int slot, int rests, int delta);
        seq_cmd_t c;
        c       = any_fields(code);
        c.note  = 7'(note);
        c.vel   = 7'(vel);
        c.slot  = 8'(slot);
        c.rests = 9'(rests);
        c.delta = 16'(delta);
        send_cmd(c);
    endtask

    task automatic run_directed();
        issue(CMD_QUERY, 0, 0, 0, 0, 0);            // empty table: bad index
        issue(CMD_PLAY, 0, 0, 0, 0, 0);             // empty table: ignored
        issue(CMD_KEY, 127, 127, 0, 0, 0);          // not recording: dropped
        issue(CMD_ALLOCATE, 0, 0, 0, 256, 0);       // fill the whole table
        issue(CMD_ALLOCATE, 0, 0, 0, 1, 0);         // table full: flag
        issue(CMD_RECORD, 0, 0, 0, 0, 0);
        issue(CMD_KEY, 0, 0, 0, 0, 0);              // table full: flag
        issue(CMD_REST, 0, 0, 0, 0, 0);
        issue(CMD_SETNOTE, 127, 0, 255, 0, 0);      // last slot
        issue(CMD_QUERY, 0, 0, 255, 0, 0);
        issue(CMD_SETREST, 0, 0, 0, 0, 0);
        issue(CMD_QUERY, 0, 0, 0, 0, 0);
        issue(CMD_CLEAR, 0, 0, 0, 0, 0);            // recording: ignored
        issue(CMD_STOP, 0, 0, 0, 0, 0);
        issue(CMD_CLEAR, 0, 0, 0, 0, 0);
        issue(CMD_SETREST, 0, 0, 0, 0, 0);          // length zero: bad index
        issue(CMD_RECORD, 0, 0, 0, 0, 0);
        issue(CMD_KEY, 127, 1, 0, 0, 0);
        issue(CMD_REST, 0, 0, 0, 0, 0);
        issue(CMD_KEY, 0, 127, 0, 0, 0);
        issue(CMD_LONGER, 0, 0, 0, 0, 65535);       // over the upper bound: refused
        issue(CMD_LONGER, 0, 0, 0, 0, 32112);       // lands just under the upper bound
        issue(CMD_SHORTER, 0, 0, 0, 0, 64225);      // would hit the lower bound: refused
        issue(CMD_SHORTER, 0, 0, 0, 0, 64224);      // lands just above the lower bound
        issue(CMD_LONGER, 0, 0, 0, 0, 32112);       // back to one half
        issue(CMD_SPARE_A, 0, 0, 0, 0, 0);
        issue(CMD_SPARE_B, 0, 0, 0, 0, 0);
    endtask

    // One musical pass: optionally wipe the table, record a short pattern, edit it,
    // then play it against a square clock wave, or random levels, with commands mixed in.
    task automatic run_session();
        seq_cmd_t c;
        int       p, h, lo, hi, k, m;
        bit       jitter;
        if (shadow.seq_len > 200 || $urandom_range(99) < 70) begin
            send_cmd(edit_fields(CMD_STOP));
            send_cmd(edit_fields(CMD_CLEAR));
        end
        if ($urandom_range(99) < 90) send_cmd(edit_fields(CMD_RECORD));
        repeat ($urandom_range(1, 10)) begin
            k = $urandom_range(99);
            send_cmd(edit_fields(k < 60 ? CMD_KEY : (k < 90 ? CMD_REST : CMD_ALLOCATE)));
        end
        repeat ($urandom_range(0, 3)) send_cmd(edit_fields(pick_edit()));
        if ($urandom_range(99) < 30) send_cmd(edit_fields(CMD_STOP));
        send_cmd(edit_fields(CMD_PLAY));

        // Shape the clock: period and duty in samples, levels from the full range.
        p = $urandom_range(2, 12);
        h = $urandom_range(1, p - 1);
        if ($urandom_range(7) == 0) begin
            lo = -32768;
            hi = 32767;
        end else begin
            lo = int'($urandom_range(0, 64000)) - 32768;
            hi = lo + 1 + int'($urandom_range(0, 32766 - lo));
        end
        jitter = ($urandom_range(5) == 0);
        m = $urandom_range(15, 60);
        for (k = 0; k < m; k++) begin
            if ($urandom_range(99) < 6) send_cmd(edit_fields(pick_side()));
            c = edit_fields(CMD_SAMPLE);
            if (!jitter) c.level = ((k % p) < h) ? 16'(hi) : 16'(lo);
            send_cmd(c);
        end
    endtask

    // Stimulus and end of run.
    initial begin
        shadow         = new();
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_cmd          = CMD_SAMPLE;
        i_clock_level  = '0;
        i_note_number  = '0;
        i_key_velocity = '0;
        i_slot         = '0;
        i_rest_count   = '0;
        i_gate_change  = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        // Mostly well-formed sessions; the rest is raw noise over every field and code.
        while (accepted_count < ITEM_GOAL) begin
            if ($urandom_range(99) < 10)
                repeat ($urandom_range(1, 3)) send_cmd(any_fields(4'($urandom_range(0, 15))));
            else
                run_session();
        end
        i_valid <= 1'b0;

        // Drain outstanding results, then give stray ones a chance to show up.
        while (shadow.pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.pending_events.size() != 0)
            shadow.report($sformatf("%0d results never arrived", shadow.pending_events.size()));
        if (shadow.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: check each accepted result transaction at the rising edge,
    // then pick the stall for the next cycle at the falling edge.
    initial begin
        seq_event_t got;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.ev_valid  = o_event_valid;
                got.ev_kind   = o_event_kind;
                got.note      = o_event_note;
                got.vel       = o_event_velocity;
                got.playing   = o_play_active;
                got.slot_rest = o_slot_is_rest;
                got.idx_err   = o_index_error;
                shadow.check_event(got);
            end
            @(negedge i_clk);
            if (hold_left > 0) begin
                // Hold the result channel so the block backs up into its input.
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && accepted_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !steady && ($urandom_range(99) < 25);
            end
        end
    end

endmodule
